/* hw/rtl/rrf_pkg.sv */
package rrf_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

  // Store addressing and pixel count widths.
  localparam int ADDR_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int TOTAL_W = $clog2(STORE_SIZE + 1);

  // Clamped size widths and physical coordinate widths.
  localparam int PW_W  = $clog2(MAX_WIDTH + 1);
  localparam int PH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Field widths fixed by the interface.
  localparam int OP_W       = 2;
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 16;
  localparam int SIZE_W     = 9;
  localparam int ROT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Opcodes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_DRAW = 2'd0,
    OP_FILL = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 2'd2;

  // Rotation codes in quarter turns.
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // Reset values of the size registers.
  localparam logic [SIZE_W-1:0] RESET_SIZE = 9'd256;

  // Effective frame geometry handed from the register block to the controller.
  typedef struct packed {
    logic [PW_W-1:0]  pw;
    logic [PH_W-1:0]  ph;
    logic [ROT_W-1:0] rot;
  } geom_t;

  // Width register clamped to 1..MAX_WIDTH.
  function automatic logic [PW_W-1:0] clamp_width(input logic [SIZE_W-1:0] v);
    logic [PW_W-1:0] r;
    if (v == '0) begin
      r = PW_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = PW_W'(MAX_WIDTH);
    end else begin
      r = PW_W'(v);
    end
    return r;
  endfunction

  // Height register clamped to 1..MAX_HEIGHT.
  function automatic logic [PH_W-1:0] clamp_height(input logic [SIZE_W-1:0] v);
    logic [PH_W-1:0] r;
    if (v == '0) begin
      r = PH_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = PH_W'(MAX_HEIGHT);
    end else begin
      r = PH_W'(v);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rrf_in_if.sv */
interface rrf_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrf_pkg::OP_W-1:0]      opcode;
  logic signed [rrf_pkg::COORD_W-1:0] pos_x;
  logic signed [rrf_pkg::COORD_W-1:0] pos_y;
  logic [rrf_pkg::COLOR_W-1:0]   color;

  modport source (output valid, output opcode, output pos_x, output pos_y, output color,
                  input ready);
  modport sink (input valid, input opcode, input pos_x, input pos_y, input color,
                output ready);
endinterface

/* hw/rtl/rrf_out_if.sv */
interface rrf_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrf_pkg::COLOR_W-1:0] pixel_color;
  logic                        last_pixel;

  modport source (output valid, output pixel_color, output last_pixel, input ready);
  modport sink (input valid, input pixel_color, input last_pixel, output ready);
endinterface

/* hw/rtl/rrf_cfg_if.sv */
interface rrf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrf_pkg::CFG_IDX_W-1:0]  index;
  logic [rrf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rrf_ram.sv */
module rrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/rrf_cfg_regs.sv */
module rrf_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  rrf_cfg_if.sink         cfg,
  output rrf_pkg::geom_t  geom
);

  logic [rrf_pkg::SIZE_W-1:0] panel_width;
  logic [rrf_pkg::SIZE_W-1:0] panel_height;
  logic [rrf_pkg::ROT_W-1:0]  rotation;

  // Writes are always taken; an index past the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= rrf_pkg::RESET_SIZE;
      panel_height <= rrf_pkg::RESET_SIZE;
      rotation     <= rrf_pkg::ROT_0;
    end else if (cfg.valid) begin
      case (cfg.index)
        rrf_pkg::REG_PANEL_WIDTH:  panel_width  <= cfg.data;
        rrf_pkg::REG_PANEL_HEIGHT: panel_height <= cfg.data;
        rrf_pkg::REG_ROTATION:     rotation     <= cfg.data[rrf_pkg::ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes out of range are pulled into 1..MAX.
  always_comb begin
    geom.pw  = rrf_pkg::clamp_width(panel_width);
    geom.ph  = rrf_pkg::clamp_height(panel_height);
    geom.rot = rotation;
  end

endmodule

/* hw/rtl/rrf_ctrl.sv */
module rrf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  rrf_pkg::geom_t geom,
  rrf_in_if.sink         pix_in,
  rrf_out_if.source      pix_out
);

  localparam int AW  = rrf_pkg::ADDR_W;
  localparam int TW  = rrf_pkg::TOTAL_W;
  localparam int CW  = rrf_pkg::COORD_W + 1;
  localparam int LW  = rrf_pkg::ROW_W + rrf_pkg::PW_W + 1;
  localparam int DW  = rrf_pkg::COLOR_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(rrf_pkg::STORE_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAW,
    ST_FILL,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  state_t state;

  // Latched input word.
  rrf_pkg::opcode_t                op_q;
  logic signed [rrf_pkg::COORD_W-1:0] x_q;
  logic signed [rrf_pkg::COORD_W-1:0] y_q;
  logic [DW-1:0]                   color_q;

  // Mapped coordinates, frame size and scan state.
  logic                            hit_q;
  logic [rrf_pkg::COL_W-1:0]       px_q;
  logic [rrf_pkg::ROW_W-1:0]       py_q;
  logic [TW-1:0]                   total_q;
  logic [AW-1:0]                   scan_ptr;
  logic [AW-1:0]                   fill_cnt;
  logic                            last_q;

  // Output register.
  logic                            out_valid;
  logic [DW-1:0]                   out_color;
  logic                            out_last;
  logic                            out_load;

  // Clip and rotate signals.
  logic [CW-1:0] xu, yu, pw_e, ph_e, lw_e, lh_e, px_e, py_e;
  logic          hit;

  // Draw address, read pointer signals.
  logic [LW-1:0] lin;
  logic [AW-1:0] draw_addr;
  logic [AW-1:0] ptr_eff;
  logic          ptr_last;

  // Memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [DW-1:0] mem_rdata;

  // Clip the logical position and map it to a physical column and row.
  always_comb begin
    xu   = CW'($unsigned(x_q));
    yu   = CW'($unsigned(y_q));
    pw_e = CW'(geom.pw);
    ph_e = CW'(geom.ph);
    lw_e = geom.rot[0] ? ph_e : pw_e;
    lh_e = geom.rot[0] ? pw_e : ph_e;
    hit  = !x_q[rrf_pkg::COORD_W-1] && !y_q[rrf_pkg::COORD_W-1] &&
           (xu < lw_e) && (yu < lh_e);
    case (geom.rot)
      rrf_pkg::ROT_90: begin
        px_e = pw_e - CW'(1) - yu;
        py_e = xu;
      end
      rrf_pkg::ROT_180: begin
        px_e = pw_e - CW'(1) - xu;
        py_e = ph_e - CW'(1) - yu;
      end
      rrf_pkg::ROT_270: begin
        px_e = yu;
        py_e = ph_e - CW'(1) - xu;
      end
      default: begin
        px_e = xu;
        py_e = yu;
      end
    endcase
  end

  // Row times physical width plus column.
  always_comb begin
    lin       = LW'(py_q) * LW'(geom.pw) + LW'(px_q);
    draw_addr = lin[AW-1:0];
  end

  // Scan pointer wraps first if the frame has shrunk below it.
  always_comb begin
    ptr_eff  = (TW'(scan_ptr) >= total_q) ? '0 : scan_ptr;
    ptr_last = (TW'(ptr_eff) == (total_q - TW'(1)));
  end

  // Memory port control.
  always_comb begin
    mem_we    = (state == ST_DRAW && hit_q) || (state == ST_FILL);
    mem_waddr = (state == ST_FILL) ? fill_cnt : draw_addr;
    mem_re    = (state == ST_RD_ADDR);
  end

  // The read word moves to the output register once that register is free.
  assign out_load = (state == ST_RD_DATA) && (!out_valid || pix_out.ready);

  rrf_ram #(
    .WIDTH (DW),
    .DEPTH (rrf_pkg::STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (color_q),
    .re    (mem_re),
    .raddr (ptr_eff),
    .rdata (mem_rdata)
  );

  assign pix_in.ready        = (state == ST_IDLE);
  assign pix_out.valid       = out_valid;
  assign pix_out.pixel_color = out_color;
  assign pix_out.last_pixel  = out_last;

  // Sequencer with its datapath and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_ptr  <= '0;
      fill_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && pix_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pix_in.valid) begin
            op_q    <= rrf_pkg::opcode_t'(pix_in.opcode);
            x_q     <= pix_in.pos_x;
            y_q     <= pix_in.pos_y;
            color_q <= pix_in.color;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          hit_q   <= hit;
          px_q    <= px_e[rrf_pkg::COL_W-1:0];
          py_q    <= py_e[rrf_pkg::ROW_W-1:0];
          total_q <= TW'(geom.pw) * TW'(geom.ph);
          case (op_q)
            rrf_pkg::OP_DRAW: state <= ST_DRAW;
            rrf_pkg::OP_FILL: state <= ST_FILL;
            rrf_pkg::OP_READ: state <= ST_RD_ADDR;
            default:          state <= ST_IDLE;
          endcase
        end
        ST_DRAW: begin
          state <= ST_IDLE;
        end
        ST_FILL: begin
          if (fill_cnt == LAST_ADDR) begin
            fill_cnt <= '0;
            state    <= ST_IDLE;
          end else begin
            fill_cnt <= fill_cnt + AW'(1);
          end
        end
        ST_RD_ADDR: begin
          last_q   <= ptr_last;
          scan_ptr <= ptr_last ? '0 : ptr_eff + AW'(1);
          state    <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          // Hold the read word until the output register is free.
          if (out_load) begin
            out_color <= mem_rdata;
            out_last  <= last_q;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // One word in flight: input is closed right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> !pix_in.ready)
    else $error("input accepted while a word is in flight");

  // A read address is always followed by the data cycle.
  a_read_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_ADDR |=> state == ST_RD_DATA)
    else $error("read data cycle skipped");

  // The advanced scan pointer stays inside the frame.
  a_ptr_in_frame: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_DATA |-> TW'(scan_ptr) < total_q)
    else $error("scan pointer beyond frame");

  // The fill sweep counter rests at zero outside a fill.
  a_fill_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_FILL |-> fill_cnt == '0)
    else $error("fill counter not at rest");

  // A result only appears after a read data cycle.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RD_DATA)
    else $error("result without a read");

endmodule

/* hw/rtl/rotated_rgb565_framebuffer.sv */
// Sequence: an accepted word is latched, then decoded; a draw is written in the
// draw state (a clipped draw writes nothing), a read addresses the store, then
// loads the output register, an unused opcode returns to idle, and a fill writes
// all MAX_WIDTH * MAX_HEIGHT store entries. One word at a time: a new word is
// taken once the last is done; a stalled output holds a read until it drains.
// Reset: control state and scan pointer clear, sizes go to 256 by 256 with no
// rotation; store contents stay undefined until written, with no clearing pass.
module rotated_rgb565_framebuffer (
  input  logic       clk,
  input  logic       rst,
  rrf_in_if.sink     pix_in,
  rrf_out_if.source  pix_out,
  rrf_cfg_if.sink    cfg
);

  rrf_pkg::geom_t geom;

  // Configuration registers and size clamping.
  rrf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .geom (geom)
  );

  // Sequencer and frame store.
  rrf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

endmodule
